/* src/scd_pkg.sv */
package scd_pkg;

  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned WBSEC_W  = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SECIN_W  = 32;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACC_FIN,
    ST_FLUSH_END
  } state_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               fill;
    logic               wb;
    logic [WBSEC_W-1:0] wbsec;
    logic               last;
  } res_t;

endpackage

/* src/scd_mem.sv */
module scd_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 49
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/scd_engine.sv */
module scd_engine #(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [scd_pkg::OP_W-1:0]                 in_op,
  input  logic [scd_pkg::SECIN_W-1:0]              in_sector,
  output logic                                     rd_en,
  output logic [$clog2(ENTRIES)-1:0]               rd_addr,
  input  logic [SECTOR_BITS+COUNT_BITS:0]          rd_data,
  output logic                                     wr_en,
  output logic [$clog2(ENTRIES)-1:0]               wr_addr,
  output logic [SECTOR_BITS+COUNT_BITS:0]          wr_data,
  input  logic                                     res_free,
  output logic                                     res_push,
  output scd_pkg::res_t                            res
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  scd_pkg::state_t state_r, state_nxt;

  logic                   is_flush_r, is_write_r;
  logic [SECTOR_BITS-1:0] sec_r;
  logic [CW-1:0]          fill_cnt_r;
  logic [IW-1:0]          vp_r;
  logic [CW-1:0]          rd_idx_r;
  logic                   dv_r;
  logic [IW-1:0]          di_r;
  logic                   hit_r;
  logic [IW-1:0]          hit_idx_r;
  logic [COUNT_BITS-1:0]  hit_cnt_r;
  logic                   hit_dirty_r;
  logic                   have_min_r;
  logic [COUNT_BITS-1:0]  min_r;
  logic [IW-1:0]          pick_r;
  logic [SECTOR_BITS-1:0] vic_tag_r;
  logic                   vic_dirty_r;
  logic                   pend_v_r;
  logic [IW-1:0]          pend_idx_r;
  logic [SECTOR_BITS-1:0] pend_tag_r;

  logic [SECTOR_BITS-1:0] cur_tag;
  logic [COUNT_BITS-1:0]  cur_cnt;
  logic                   cur_dirty;
  logic                   accept, scanning, stall, issue, scan_done, flush_hit;
  logic                   acc_eval, take_min, take_tie, room;
  logic [COUNT_BITS-1:0]  hit_cnt_sat;

  assign cur_tag   = rd_data[SECTOR_BITS+COUNT_BITS -: SECTOR_BITS];
  assign cur_cnt   = rd_data[COUNT_BITS:1];
  assign cur_dirty = rd_data[0];

  assign accept    = (state_r == scd_pkg::ST_IDLE) && in_valid;
  assign scanning  = (state_r == scd_pkg::ST_SCAN);
  assign stall     = scanning && is_flush_r && dv_r && cur_dirty && pend_v_r && !res_free;
  assign issue     = scanning && !stall && (rd_idx_r < fill_cnt_r);
  assign scan_done = scanning && !dv_r && (rd_idx_r == fill_cnt_r);
  assign flush_hit = scanning && is_flush_r && dv_r && cur_dirty && !stall;
  assign acc_eval  = scanning && !is_flush_r && dv_r;
  assign take_min  = !have_min_r || (cur_cnt < min_r);
  assign take_tie  = (cur_cnt == min_r) && (pick_r < vp_r) && (vp_r <= di_r);
  assign room      = fill_cnt_r < CW'(ENTRIES);
  assign hit_cnt_sat = (hit_cnt_r == {COUNT_BITS{1'b1}}) ? hit_cnt_r
                                                         : hit_cnt_r + COUNT_BITS'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scd_pkg::ST_IDLE: begin
        if (in_valid && (in_op == scd_pkg::OP_READ || in_op == scd_pkg::OP_WRITE ||
                         in_op == scd_pkg::OP_FLUSH)) begin
          state_nxt = scd_pkg::ST_SCAN;
        end
      end
      scd_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = is_flush_r ? scd_pkg::ST_FLUSH_END : scd_pkg::ST_ACC_FIN;
        end
      end
      scd_pkg::ST_ACC_FIN, scd_pkg::ST_FLUSH_END: begin
        if (res_free) begin
          state_nxt = scd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == scd_pkg::ST_IDLE);
    rd_en    = issue;
    rd_addr  = rd_idx_r[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = di_r;
    wr_data  = {cur_tag, cur_cnt, 1'b0};
    res_push = 1'b0;
    res      = '0;
    unique case (state_r)
      scd_pkg::ST_SCAN: begin
        if (flush_hit) begin
          wr_en = 1'b1;
          if (pend_v_r) begin
            res_push  = 1'b1;
            res.slot  = scd_pkg::SLOT_W'(pend_idx_r);
            res.wb    = 1'b1;
            res.wbsec = scd_pkg::WBSEC_W'(pend_tag_r);
          end
        end
      end
      scd_pkg::ST_ACC_FIN: begin
        if (res_free) begin
          wr_en    = 1'b1;
          res_push = 1'b1;
          res.last = 1'b1;
          if (hit_r) begin
            wr_addr  = hit_idx_r;
            wr_data  = {sec_r, hit_cnt_sat, hit_dirty_r | is_write_r};
            res.slot = scd_pkg::SLOT_W'(hit_idx_r);
            res.hit  = 1'b1;
          end else if (room) begin
            wr_addr  = fill_cnt_r[IW-1:0];
            wr_data  = {sec_r, COUNT_BITS'(1), is_write_r};
            res.slot = scd_pkg::SLOT_W'(fill_cnt_r[IW-1:0]);
            res.fill = 1'b1;
          end else begin
            wr_addr   = pick_r;
            wr_data   = {sec_r, COUNT_BITS'(1), is_write_r};
            res.slot  = scd_pkg::SLOT_W'(pick_r);
            res.fill  = 1'b1;
            res.wb    = vic_dirty_r;
            res.wbsec = vic_dirty_r ? scd_pkg::WBSEC_W'(vic_tag_r) : '0;
          end
        end
      end
      scd_pkg::ST_FLUSH_END: begin
        if (res_free) begin
          res_push = 1'b1;
          res.last = 1'b1;
          if (pend_v_r) begin
            res.slot  = scd_pkg::SLOT_W'(pend_idx_r);
            res.wb    = 1'b1;
            res.wbsec = scd_pkg::WBSEC_W'(pend_tag_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= scd_pkg::ST_IDLE;
      fill_cnt_r <= '0;
      vp_r       <= '0;
      dv_r       <= 1'b0;
      hit_r      <= 1'b0;
      have_min_r <= 1'b0;
      pend_v_r   <= 1'b0;
      rd_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        rd_idx_r   <= '0;
        dv_r       <= 1'b0;
        hit_r      <= 1'b0;
        have_min_r <= 1'b0;
        pend_v_r   <= 1'b0;
      end
      if (scanning && !stall) begin
        dv_r <= issue;
        if (issue) begin
          rd_idx_r <= rd_idx_r + CW'(1);
        end
      end
      if (acc_eval) begin
        if (!hit_r && cur_tag == sec_r) begin
          hit_r <= 1'b1;
        end
        if (take_min) begin
          have_min_r <= 1'b1;
        end
      end
      if (flush_hit) begin
        pend_v_r <= 1'b1;
      end
      if (state_r == scd_pkg::ST_ACC_FIN && res_free && !hit_r) begin
        if (room) begin
          fill_cnt_r <= fill_cnt_r + CW'(1);
        end else begin
          vp_r <= (vp_r == IW'(ENTRIES - 1)) ? '0 : vp_r + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_flush_r <= (in_op == scd_pkg::OP_FLUSH);
      is_write_r <= (in_op == scd_pkg::OP_WRITE);
      sec_r      <= SECTOR_BITS'(in_sector);
    end
    if (scanning && !stall) begin
      di_r <= rd_idx_r[IW-1:0];
    end
    if (acc_eval) begin
      if (!hit_r && cur_tag == sec_r) begin
        hit_idx_r   <= di_r;
        hit_cnt_r   <= cur_cnt;
        hit_dirty_r <= cur_dirty;
      end
      if (take_min || take_tie) begin
        pick_r      <= di_r;
        min_r       <= cur_cnt;
        vic_tag_r   <= cur_tag;
        vic_dirty_r <= cur_dirty;
      end
    end
    if (flush_hit) begin
      pend_idx_r <= di_r;
      pend_tag_r <= cur_tag;
    end
  end

endmodule

/* src/scd_out.sv */
module scd_out (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scd_pkg::res_t d,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output scd_pkg::res_t q
);

  logic valid_r, valid_nxt;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign valid_nxt = push ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q <= d;
    end
  end

endmodule

/* src/sector_cache_directory_lfu.sv */
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | in_tdata: op[1:0], sector[33:2], zero pad
// out     | out | out_tvalid/tready  | out_tdata: slot, hit, fill, wb, wb sector; out_tlast
//
// One word at a time. A read or write walks the filled entries in the directory memory,
// one per cycle, then updates one entry. A flush takes the same walk and sends each
// dirty entry once the walk reaches the next dirty one (the last at the end); it halts
// when a send is due while the output register is full. Reset is synchronous; entries
// fill in index order, so a fill count replaces valid bits. A result waits in the
// output register while the next word is taken.
module sector_cache_directory_lfu #(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned COUNT_BITS  = 16,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], sector[33:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // slot[5:0], hit[6], fill_needed[7],
                                  // writeback_needed[8], writeback_sector[40:9]
  output logic        out_tlast
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned MW = SECTOR_BITS + COUNT_BITS + 1;

  logic          rd_en, wr_en, res_free, res_push;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] rd_data, wr_data;
  scd_pkg::res_t res, res_q;

  scd_mem #(
    .DEPTH(ENTRIES),
    .WIDTH(MW)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  scd_engine #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .SECTOR_BITS(SECTOR_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tdata[1:0]),
    .in_sector(in_tdata[33:2]),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res_free (res_free),
    .res_push (res_push),
    .res      (res)
  );

  scd_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .d        (res),
    .free     (res_free),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .q        (res_q)
  );

  assign out_tdata = {7'b0, res_q.wbsec, res_q.wb, res_q.fill, res_q.hit, res_q.slot};
  assign out_tlast = res_q.last;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int NENT = 64;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int N_ROWS = 16;
  localparam int N_RAND = 350;
  localparam int POOL_SZ = 96;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [1:0]    op;
    logic [31:0]   sector;
    bit            typed;
    scd_pkg::res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // op[1:0], sector[33:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // slot[5:0], hit, fill, wb, wb sector[40:9]
  logic        out_tlast;

  sector_cache_directory_lfu i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // directory shadow
  bit          dir_valid [NENT];
  logic [31:0] dir_tag   [NENT];
  logic [15:0] dir_cnt   [NENT];
  bit          dir_dirty [NENT];
  int          victim_ptr;

  scd_pkg::res_t step_res[$];
  scd_pkg::res_t due_results[$];
  int          n_err = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;
  logic [31:0] pool [POOL_SZ];
  dir_row_t    rows [N_ROWS];

  function automatic scd_pkg::res_t mk_res(int slot, bit hit, bit fill, bit wb,
                                           logic [31:0] wbsec, bit last);
    scd_pkg::res_t r;
    r.slot  = slot[scd_pkg::SLOT_W-1:0];
    r.hit   = hit;
    r.fill  = fill;
    r.wb    = wb;
    r.wbsec = wbsec;
    r.last  = last;
    return r;
  endfunction

  function automatic void predict_step(logic [1:0] op, logic [31:0] sec);
    int i;
    int pick;
    int hit_idx;
    logic [15:0] min_cnt;
    bit have_min;
    bit wr;
    bit wb;
    logic [31:0] wbsec;
    step_res.delete();
    if (op == scd_pkg::OP_FLUSH) begin
      for (i = 0; i < NENT; i++) begin
        if (dir_valid[i] && dir_dirty[i]) begin
          step_res.push_back(mk_res(i, 1'b0, 1'b0, 1'b1, dir_tag[i], 1'b0));
          dir_dirty[i] = 1'b0;
        end
      end
      if (step_res.size() == 0)
        step_res.push_back(mk_res(0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1));
      else
        step_res[step_res.size()-1].last = 1'b1;
      return;
    end
    if (op != scd_pkg::OP_READ && op != scd_pkg::OP_WRITE)
      return;
    wr = (op == scd_pkg::OP_WRITE);
    hit_idx = -1;
    for (i = 0; i < NENT; i++)
      if (hit_idx < 0 && dir_valid[i] && dir_tag[i] == sec)
        hit_idx = i;
    if (hit_idx >= 0) begin
      if (dir_cnt[hit_idx] != CNT_MAX)
        dir_cnt[hit_idx] = dir_cnt[hit_idx] + 16'd1;
      if (wr)
        dir_dirty[hit_idx] = 1'b1;
      step_res.push_back(mk_res(hit_idx, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1));
      return;
    end
    pick = 0;
    min_cnt = '0;
    have_min = 1'b0;
    wb = 1'b0;
    wbsec = '0;
    for (i = 0; i < NENT; i++) begin
      if (!dir_valid[i])
        break;
      if (!have_min || dir_cnt[i] < min_cnt) begin
        pick = i;
        min_cnt = dir_cnt[i];
        have_min = 1'b1;
      end else if (dir_cnt[i] == min_cnt && pick < victim_ptr && victim_ptr <= i) begin
        pick = i;
      end
    end
    if (i < NENT) begin
      pick = i;
    end else begin
      if (dir_dirty[pick]) begin
        wb = 1'b1;
        wbsec = dir_tag[pick];
      end
      victim_ptr = (victim_ptr + 1) % NENT;
    end
    dir_valid[pick] = 1'b1;
    dir_tag[pick] = sec;
    dir_cnt[pick] = 16'd1;
    dir_dirty[pick] = wr;
    step_res.push_back(mk_res(pick, 1'b0, 1'b1, wb, wbsec, 1'b1));
  endfunction

  task automatic send_word(logic [1:0] op, logic [31:0] sec, bit typed,
                           scd_pkg::res_t typed_res);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 5) == 0)
      gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, sec, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_step(op, sec);
    if (typed)
      due_results.push_back(typed_res);
    else
      foreach (step_res[j]) due_results.push_back(step_res[j]);
  endtask

  function automatic void mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    n_err++;
    if (n_err <= MAX_REPORTS)
      $error("%s: expected 'h%0h, got 'h%0h", field, exp_v, got_v);
  endfunction

  // result checker
  always @(posedge clk) begin
    scd_pkg::res_t got;
    scd_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot  = out_tdata[5:0];
      got.hit   = out_tdata[6];
      got.fill  = out_tdata[7];
      got.wb    = out_tdata[8];
      got.wbsec = out_tdata[40:9];
      got.last  = out_tlast;
      if (due_results.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $error("unexpected word: slot %0d last %0b", got.slot, got.last);
      end else begin
        want = due_results.pop_front();
        if (got.slot !== want.slot) mismatch("slot", want.slot, got.slot);
        if (got.hit !== want.hit) mismatch("hit", want.hit, got.hit);
        if (got.fill !== want.fill) mismatch("fill_needed", want.fill, got.fill);
        if (got.wb !== want.wb) mismatch("writeback_needed", want.wb, got.wb);
        if (got.wbsec !== want.wbsec) mismatch("writeback_sector", want.wbsec, got.wbsec);
        if (got.last !== want.last) mismatch("last", want.last, got.last);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver backpressure
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    int k;
    int r;
    logic [1:0] op;
    logic [31:0] sec;
    for (k = 0; k < NENT; k++) begin
      dir_valid[k] = 1'b0;
      dir_tag[k] = '0;
      dir_cnt[k] = '0;
      dir_dirty[k] = 1'b0;
    end
    victim_ptr = 0;
    rows = '{
      '{scd_pkg::OP_FLUSH, 32'h0000_0000, 1'b1, mk_res(0, 0, 0, 0, 32'd0, 1)},
      '{scd_pkg::OP_READ,  32'h0000_0000, 1'b1, mk_res(0, 0, 1, 0, 32'd0, 1)},
      '{scd_pkg::OP_WRITE, 32'hFFFF_FFFF, 1'b1, mk_res(1, 0, 1, 0, 32'd0, 1)},
      '{scd_pkg::OP_READ,  32'h0000_0000, 1'b1, mk_res(0, 1, 0, 0, 32'd0, 1)},
      '{scd_pkg::OP_WRITE, 32'h0000_0000, 1'b1, mk_res(0, 1, 0, 0, 32'd0, 1)},
      '{OP_UNDEF,          32'h0000_0005, 1'b0, '0},
      '{scd_pkg::OP_READ,  32'hFFFF_FFFF, 1'b1, mk_res(1, 1, 0, 0, 32'd0, 1)},
      '{scd_pkg::OP_WRITE, 32'hAAAA_AAAA, 1'b1, mk_res(2, 0, 1, 0, 32'd0, 1)},
      '{scd_pkg::OP_READ,  32'h5555_5555, 1'b1, mk_res(3, 0, 1, 0, 32'd0, 1)},
      '{scd_pkg::OP_FLUSH, 32'h1234_5678, 1'b0, '0},
      '{scd_pkg::OP_FLUSH, 32'h0000_0000, 1'b1, mk_res(0, 0, 0, 0, 32'd0, 1)},
      '{OP_UNDEF,          32'hFFFF_FFFF, 1'b0, '0},
      '{scd_pkg::OP_WRITE, 32'h8000_0001, 1'b1, mk_res(4, 0, 1, 0, 32'd0, 1)},
      '{scd_pkg::OP_READ,  32'h8000_0001, 1'b1, mk_res(4, 1, 0, 0, 32'd0, 1)},
      '{scd_pkg::OP_WRITE, 32'h5555_5555, 1'b1, mk_res(3, 1, 0, 0, 32'd0, 1)},
      '{scd_pkg::OP_FLUSH, 32'h0000_0000, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_ROWS; k++)
      send_word(rows[k].op, rows[k].sector, rows[k].typed, rows[k].res);

    pool[0] = 32'h0000_0000;
    pool[1] = 32'hFFFF_FFFF;
    for (k = 2; k < POOL_SZ; k++)
      pool[k] = $urandom;

    for (k = 0; k < N_RAND; k++) begin
      if (k == 60)
        hold_req = 1'b1;
      if (k == 150) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0) @(posedge clk);
      end
      if (k == N_RAND - 60)
        no_idle = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 44)
        op = scd_pkg::OP_READ;
      else if (r < 84)
        op = scd_pkg::OP_WRITE;
      else if (r < 92)
        op = scd_pkg::OP_FLUSH;
      else if (r < 96)
        op = OP_UNDEF;
      else
        op = scd_pkg::OP_READ;
      if (r >= 96 || $urandom_range(0, 99) >= 85)
        sec = $urandom;
      else
        sec = pool[$urandom_range(0, POOL_SZ - 1)];
      send_word(op, sec, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
